// ----- hw/rtl/mtep_pkg.sv -----
`default_nettype none
package mtep_pkg;

   localparam int DELTA_W     = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0] DATA_MAX    = 8'h7F;
   localparam logic [7:0] TWO_MAX     = 8'hBF;
   localparam logic [7:0] ONE_MAX     = 8'hDF;
   localparam logic [7:0] CHAN_MAX    = 8'hEF;
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] META_START  = 8'hFF;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] META_EOT    = 8'h2F;

   localparam logic [2:0] ROLE_DELAY   = 3'd0;
   localparam logic [2:0] ROLE_STATUS  = 3'd1;
   localparam logic [2:0] ROLE_PARAM   = 3'd2;
   localparam logic [2:0] ROLE_SYSEX   = 3'd3;
   localparam logic [2:0] ROLE_MTYPE   = 3'd4;
   localparam logic [2:0] ROLE_MLEN    = 3'd5;
   localparam logic [2:0] ROLE_MDATA   = 3'd6;
   localparam logic [2:0] ROLE_IGNORED = 3'd7;

   localparam logic [3:0] CLASS_NONE  = 4'd0;
   localparam logic [3:0] CLASS_SYSEX = 4'd7;
   localparam logic [3:0] CLASS_META  = 4'd8;

   typedef enum logic [2:0] {
      PH_DELAY,
      PH_STATUS,
      PH_PARAM,
      PH_SYSEX,
      PH_MTYPE,
      PH_MLEN,
      PH_MDATA,
      PH_DEAD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
   } mtep_req_type;

   typedef struct packed {
      logic [7:0]         byte_value;
      logic [2:0]         byte_role;
      logic [7:0]         status_in_effect;
      logic [3:0]         event_class;
      logic               event_done;
      logic [DELTA_W-1:0] delta_time;
      logic               running_status_used;
      logic               track_end;
      logic               bad_status;
   } mtep_rsp_type;

   // pre-decoded byte as it travels from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
      logic       is_data;
      logic       is_chan;
      logic       is_sysex;
      logic       is_meta;
      logic       is_eox;
      logic       is_eot;
      logic       is_zero;
      logic       two_params;
   } mtep_tag_type;

   function automatic logic [3:0] class_of(input logic [7:0] st);
      logic [3:0] cls;
      cls = CLASS_NONE;
      if (st[7] && st <= CHAN_MAX) begin
         cls = {1'b0, st[6:4]};
      end else if (st == SYSEX_START) begin
         cls = CLASS_SYSEX;
      end else if (st == META_START) begin
         cls = CLASS_META;
      end
      return cls;
   endfunction

   function automatic logic [1:0] param_count(input logic [7:0] st);
      logic [1:0] n;
      n = 2'd2;
      if (st > TWO_MAX && st <= ONE_MAX) begin
         n = 2'd1;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mtep_front.sv -----
`default_nettype none
module mtep_front
   import mtep_pkg::*;
(
   input  wire logic         push,
   input  wire mtep_req_type req_data,
   input  wire logic         q_full,
   output logic              q_push,
   output mtep_tag_type      q_tag
);

   logic [7:0] b;

   assign b      = req_data.data_byte;
   assign q_push = push && !q_full;

   always_comb begin
      q_tag             = '0;
      q_tag.data_byte   = b;
      q_tag.track_start = req_data.track_start;
      q_tag.is_data     = (b <= DATA_MAX);
      q_tag.is_chan     = b[7] && (b <= CHAN_MAX);
      q_tag.is_sysex    = (b == SYSEX_START);
      q_tag.is_meta     = (b == META_START);
      q_tag.is_eox      = (b == SYSEX_END);
      q_tag.is_eot      = (b == META_EOT);
      q_tag.is_zero     = (b == 8'd0);
      q_tag.two_params  = (param_count(b) == 2'd2);
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mtep_queue.sv -----
`default_nettype none
module mtep_queue
   import mtep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_en,
   input  wire mtep_tag_type wr_tag,
   input  wire logic         rd_en,
   output mtep_tag_type      rd_tag,
   output logic              q_full,
   output logic              q_valid
);

   mtep_tag_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;
   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_tag  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_tag;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mtep_back.sv -----
`default_nettype none
module mtep_back
   import mtep_pkg::*;
#(
   parameter int DELAY_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire mtep_tag_type q_tag,
   output logic              q_pop,
   input  wire logic         pop,
   output logic              empty,
   output mtep_rsp_type      rsp_data
);

   phase_type              phase_ff, phase_in, ph;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in, acc;
   logic [7:0]             last_ff, last_in, last;
   logic [7:0]             cur_ff, cur_in, cur;
   logic [1:0]             params_ff, params_in, params;
   logic [7:0]             meta_ff, meta_in, meta;
   logic                   reused_ff, reused_in, reused;
   logic                   valid_ff, valid_in;
   mtep_rsp_type           rsp_ff, rsp_in;
   logic [7:0]             b;
   logic [DELAY_WIDTH-1:0] dt;
   logic [DELAY_WIDTH-1:0] acc_shift;
   logic                   done, bad, tend;
   logic [2:0]             role;
   logic [1:0]             last_params;

   assign q_pop    = q_valid && (!valid_ff || pop);
   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;
   assign b        = q_tag.data_byte;

   always_comb begin
      // track start clears the parser before this byte
      ph     = q_tag.track_start ? PH_DELAY : phase_ff;
      acc    = q_tag.track_start ? '0 : delay_ff;
      last   = q_tag.track_start ? '0 : last_ff;
      cur    = q_tag.track_start ? '0 : cur_ff;
      params = q_tag.track_start ? '0 : params_ff;
      meta   = q_tag.track_start ? '0 : meta_ff;
      reused = q_tag.track_start ? 1'b0 : reused_ff;

      acc_shift   = {acc[DELAY_WIDTH-8:0], b[6:0]};
      last_params = param_count(last);

      phase_in  = ph;
      delay_in  = acc;
      last_in   = last;
      cur_in    = cur;
      params_in = params;
      meta_in   = meta;
      reused_in = reused;
      done      = 1'b0;
      bad       = 1'b0;
      tend      = 1'b0;
      role      = ROLE_IGNORED;
      dt        = acc;

      case (ph)
         PH_DELAY: begin
            role     = ROLE_DELAY;
            delay_in = acc_shift;
            dt       = acc_shift;
            if (!b[7]) begin
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: begin
            role = ROLE_STATUS;
            if (q_tag.is_data) begin
               if (last == 8'd0) begin
                  bad      = 1'b1;
                  cur_in   = '0;
                  phase_in = PH_DEAD;
               end else begin
                  cur_in    = last;
                  reused_in = 1'b1;
                  role      = ROLE_PARAM;
                  params_in = last_params - 2'd1;
                  if (last_params == 2'd1) begin
                     done     = 1'b1;
                     phase_in = PH_DELAY;
                  end else begin
                     phase_in = PH_PARAM;
                  end
               end
            end else if (q_tag.is_chan) begin
               cur_in    = b;
               last_in   = b;
               reused_in = 1'b0;
               params_in = q_tag.two_params ? 2'd2 : 2'd1;
               phase_in  = PH_PARAM;
            end else if (q_tag.is_sysex) begin
               cur_in    = b;
               reused_in = 1'b0;
               phase_in  = PH_SYSEX;
            end else if (q_tag.is_meta) begin
               cur_in    = b;
               reused_in = 1'b0;
               phase_in  = PH_MTYPE;
            end else begin
               bad      = 1'b1;
               cur_in   = b;
               phase_in = PH_DEAD;
            end
         end
         PH_PARAM: begin
            role      = ROLE_PARAM;
            params_in = params - 2'd1;
            if (params == 2'd1) begin
               done     = 1'b1;
               phase_in = PH_DELAY;
            end
         end
         PH_SYSEX: begin
            role = ROLE_SYSEX;
            if (q_tag.is_eox) begin
               done     = 1'b1;
               phase_in = PH_DELAY;
            end
         end
         PH_MTYPE: begin
            role = ROLE_MTYPE;
            if (q_tag.is_eot) begin
               tend     = 1'b1;
               done     = 1'b1;
               phase_in = PH_DEAD;
            end else begin
               phase_in = PH_MLEN;
            end
         end
         PH_MLEN: begin
            role    = ROLE_MLEN;
            meta_in = b;
            if (q_tag.is_zero) begin
               done     = 1'b1;
               phase_in = PH_DELAY;
            end else begin
               phase_in = PH_MDATA;
            end
         end
         PH_MDATA: begin
            role    = ROLE_MDATA;
            meta_in = meta - 8'd1;
            if (meta == 8'd1) begin
               done     = 1'b1;
               phase_in = PH_DELAY;
            end
         end
         default: begin
            role = ROLE_IGNORED;
         end
      endcase

      rsp_in            = '0;
      rsp_in.byte_value = b;
      rsp_in.byte_role  = role;
      rsp_in.event_done = done;
      rsp_in.track_end  = tend;
      rsp_in.bad_status = bad;
      if (role == ROLE_DELAY) begin
         rsp_in.delta_time = DELTA_W'(dt);
      end else if (role != ROLE_IGNORED) begin
         rsp_in.delta_time          = DELTA_W'(dt);
         rsp_in.status_in_effect    = cur_in;
         rsp_in.event_class         = bad ? CLASS_NONE : class_of(cur_in);
         rsp_in.running_status_used = reused_in;
      end

      if (done || bad) begin
         delay_in  = '0;
         cur_in    = '0;
         reused_in = 1'b0;
         params_in = '0;
         meta_in   = '0;
      end

      valid_in = q_pop || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELAY;
         delay_ff  <= '0;
         last_ff   <= '0;
         cur_ff    <= '0;
         params_ff <= '0;
         meta_ff   <= '0;
         reused_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop) begin
            phase_ff  <= phase_in;
            delay_ff  <= delay_in;
            last_ff   <= last_in;
            cur_ff    <= cur_in;
            params_ff <= params_in;
            meta_ff   <= meta_in;
            reused_ff <= reused_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/midi_track_event_parser_unit.sv -----
// midi track event parser
// input queue: drive req_data and raise push; a request is taken at a rising
//    edge where push is high and full is low. one request per track byte.
//    set track_start on the first byte of a track to clear the parser.
// result queue: while empty is low, rsp_data holds the result of the oldest
//    byte; raise pop to take it. exactly one result per request, in order.
// a front stage decodes each byte and writes it into a four-entry queue;
//    a back stage runs the parser state and loads the result register.
// each request is written into the queue at the accepting edge; the parser step
//    then loads its result into the result register once that is free or popped.
// throughput: one request per cycle, sustained, as long as results are
//    popped; the parser step in the back stage sets this.
// when pop stays low the result register holds, the queue fills, and full
//    rises after four more requests; nothing is dropped.
// reset clears the queue, the result register valid and all parser state;
//    full is low after reset, so the block accepts requests right away.
// DELAY_WIDTH (28 to 32) sets the delta time accumulator width; it wraps.
`default_nettype none
module midi_track_event_parser_unit
   import mtep_pkg::*;
#(
   parameter int DELAY_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire mtep_req_type req_data,
   output logic              empty,
   input  wire logic         pop,
   output mtep_rsp_type      rsp_data
);

   logic         q_push;
   mtep_tag_type q_wr_tag;
   mtep_tag_type q_rd_tag;
   logic         q_full;
   logic         q_valid;
   logic         q_pop;

   assign full = q_full;

   mtep_front u_front (
      .push     (push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_tag    (q_wr_tag)
   );

   mtep_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_tag  (q_wr_tag),
      .rd_en   (q_pop),
      .rd_tag  (q_rd_tag),
      .q_full  (q_full),
      .q_valid (q_valid)
   );

   mtep_back #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_tag    (q_rd_tag),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
